>>> hdl/nsb_pkg.sv
// Shared types, constants and helpers for the neighbor solicitation builder.
package nsb_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned ACC_W      = 21;

  localparam logic [3:0] LAST_WORD_IDX = 4'd10;
  localparam logic [3:0] FULL_BYTES    = 4'd8;
  localparam logic [3:0] LAST_BYTES    = 4'd6;

  typedef enum logic [4:0] {
    STEP_SRC  = 5'b00001,
    STEP_THI  = 5'b00010,
    STEP_TLO  = 5'b00100,
    STEP_MAC  = 5'b01000,
    STEP_FOLD = 5'b10000
  } step_e;

  // payload length, next header, type/code word, option type/length word
  localparam logic [ACC_W-1:0] CK_CONST = ACC_W'(32 + 58 + 16'h8700 + 16'h0101);

  typedef enum logic [1:0] {
    REG_SRC_ADDR_HI = 2'd0,
    REG_SRC_ADDR_LO = 2'd1,
    REG_SRC_MAC     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [47:0] src_mac;
  } cfg_t;

  typedef struct packed {
    logic [63:0] thi;
    logic [63:0] tlo;
    logic [15:0] cksum;
  } req_t;

  function automatic logic [17:0] sum4(input logic [63:0] v);
    logic [17:0] s;
    s = {2'b00, v[63:48]} + {2'b00, v[47:32]} + {2'b00, v[31:16]} + {2'b00, v[15:0]};
    return s;
  endfunction

endpackage

>>> hdl/nsb_regs.sv
// APB configuration registers: own IPv6 source address and MAC.
module nsb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nsb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [nsb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [nsb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output nsb_pkg::cfg_t                   cfg_o
);

  nsb_pkg::cfg_t    cfg_q;
  nsb_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = nsb_pkg::reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        nsb_pkg::REG_SRC_ADDR_HI: cfg_q.src_addr_hi <= pwdata;
        nsb_pkg::REG_SRC_ADDR_LO: cfg_q.src_addr_lo <= pwdata;
        nsb_pkg::REG_SRC_MAC:     cfg_q.src_mac     <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      nsb_pkg::REG_SRC_ADDR_HI: prdata = cfg_q.src_addr_hi;
      nsb_pkg::REG_SRC_ADDR_LO: prdata = cfg_q.src_addr_lo;
      nsb_pkg::REG_SRC_MAC:     prdata = {16'h0000, cfg_q.src_mac};
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> hdl/nsb_front.sv
// Request intake and ICMPv6 checksum accumulation.
module nsb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nsb_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [63:0]   target_addr_hi_i,
  input  logic [63:0]   target_addr_lo_i,
  input  logic          q_full_i,
  output logic          push_o,
  output nsb_pkg::req_t push_data_o
);

  logic                      busy_q;
  nsb_pkg::step_e            step_q, step_d;
  logic [63:0]               thi_q, tlo_q;
  logic [nsb_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [16:0]               fold1, fold2;
  logic                      accept;
  logic [17:0]               mac_sum;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = busy_q && (step_q == nsb_pkg::STEP_FOLD) && !q_full_i;

  assign mac_sum = {2'b00, cfg_i.src_mac[47:32]} + {2'b00, cfg_i.src_mac[31:16]}
                 + {2'b00, cfg_i.src_mac[15:0]};

  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    case (step_q)
      nsb_pkg::STEP_SRC: begin
        acc_d  = nsb_pkg::ACC_W'(nsb_pkg::sum4(cfg_i.src_addr_hi))
               + nsb_pkg::ACC_W'(nsb_pkg::sum4(cfg_i.src_addr_lo));
        step_d = nsb_pkg::STEP_THI;
      end
      // target address is summed twice: IPv6 destination and NS target
      nsb_pkg::STEP_THI: begin
        acc_d  = acc_q + nsb_pkg::ACC_W'({nsb_pkg::sum4(thi_q), 1'b0});
        step_d = nsb_pkg::STEP_TLO;
      end
      nsb_pkg::STEP_TLO: begin
        acc_d  = acc_q + nsb_pkg::ACC_W'({nsb_pkg::sum4(tlo_q), 1'b0});
        step_d = nsb_pkg::STEP_MAC;
      end
      nsb_pkg::STEP_MAC: begin
        acc_d  = acc_q + nsb_pkg::ACC_W'(mac_sum) + nsb_pkg::CK_CONST;
        step_d = nsb_pkg::STEP_FOLD;
      end
      default: ;
    endcase
  end

  assign fold1 = {1'b0, acc_q[15:0]} + 17'(acc_q[nsb_pkg::ACC_W-1:16]);
  assign fold2 = {1'b0, fold1[15:0]} + 17'(fold1[16]);

  assign push_data_o.thi   = thi_q;
  assign push_data_o.tlo   = tlo_q;
  assign push_data_o.cksum = ~fold2[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= nsb_pkg::STEP_SRC;
    end else if (accept) begin
      busy_q <= 1'b1;
      step_q <= nsb_pkg::STEP_SRC;
    end else if (busy_q) begin
      if (step_q != nsb_pkg::STEP_FOLD) begin
        step_q <= step_d;
      end else if (!q_full_i) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      thi_q <= target_addr_hi_i;
      tlo_q <= target_addr_lo_i;
    end
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> busy_q && !q_full_i)
    else $error("push without a finished checksum");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot(step_q))
    else $error("checksum step out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> !busy_q)
    else $error("front still busy after push");

endmodule

>>> hdl/nsb_queue.sv
// Two-entry queue between the checksum front and the frame serializer.
module nsb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nsb_pkg::req_t push_data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output nsb_pkg::req_t head_o
);

  nsb_pkg::req_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'd2)
    else $error("queue count out of range");

endmodule

>>> hdl/nsb_back.sv
// Frame serializer: eleven 64-bit beats per request through an output register.
module nsb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nsb_pkg::cfg_t cfg_i,
  input  logic          empty_i,
  input  nsb_pkg::req_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [63:0]   frame_word_o,
  output logic [3:0]    valid_bytes_o,
  output logic          last_word_o
);

  logic [3:0]  word_q;
  logic        out_valid_q;
  logic [63:0] data_q;
  logic [3:0]  bytes_q;
  logic        last_q;
  logic [63:0] word_d;
  logic        load, is_last;

  assign load    = !empty_i && (!out_valid_q || out_ready_i);
  assign is_last = (word_q == nsb_pkg::LAST_WORD_IDX);
  assign pop_o   = load && is_last;

  always_comb begin
    case (word_q)
      4'd0:    word_d = {24'h3333ff, head_i.tlo[23:0], cfg_i.src_mac[47:32]};
      4'd1:    word_d = {cfg_i.src_mac[31:0], 32'h86dd6000};
      4'd2:    word_d = {48'h000000203aff, cfg_i.src_addr_hi[63:48]};
      4'd3:    word_d = {cfg_i.src_addr_hi[47:0], cfg_i.src_addr_lo[63:48]};
      4'd4:    word_d = {cfg_i.src_addr_lo[47:0], head_i.thi[63:48]};
      4'd5:    word_d = {head_i.thi[47:0], head_i.tlo[63:48]};
      4'd6:    word_d = {head_i.tlo[47:0], 16'h8700};
      4'd7:    word_d = {head_i.cksum, 32'h00000000, head_i.thi[63:48]};
      4'd8:    word_d = {head_i.thi[47:0], head_i.tlo[63:48]};
      4'd9:    word_d = {head_i.tlo[47:0], 16'h0101};
      4'd10:   word_d = {cfg_i.src_mac, 16'h0000};
      default: word_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        word_q      <= is_last ? 4'd0 : word_q + 4'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q  <= word_d;
      bytes_q <= is_last ? nsb_pkg::LAST_BYTES : nsb_pkg::FULL_BYTES;
      last_q  <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_word_o  = data_q;
  assign valid_bytes_o = bytes_q;
  assign last_word_o   = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_q <= nsb_pkg::LAST_WORD_IDX)
    else $error("word index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> word_q == 4'd0 && out_valid_q && last_q)
    else $error("pop not aligned with last beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !is_last) |=> !last_q && bytes_q == nsb_pkg::FULL_BYTES)
    else $error("inner beat marked as last");

endmodule

>>> hdl/ipv6_neighbor_solicit_builder_core.sv
// Top level of the IPv6 neighbor solicitation frame builder.
// Usage:
//   Each request beat on the input channel (in_valid_i/in_ready_o) carries a
//   128-bit target address. The block answers with one 86-byte Ethernet frame
//   holding an ICMPv6 neighbor solicitation, as eleven 64-bit beats on the
//   output channel (out_valid_o/out_ready_i), first byte in bits 63..56;
//   last_word_o marks the final beat, which carries six valid bytes.
//   Own IPv6 source address and MAC are set over the APB port (registers at
//   byte addresses 0, 8, 16); the user must set them only while the block is
//   idle, since the block itself does not enforce this.
//   After a request is taken, the front accumulates the checksum in the steps
//   source address, target high, target low, MAC with constants, and fold,
//   and pushes the result into the queue once it has room. The serializer
//   emits one beat per cycle while the queue holds a request and the
//   receiver is ready. A two-entry queue lets the front take and checksum
//   later requests while a frame is still being sent.
// Reset clears the registers to zero and empties the queue and output stage.
// When the receiver stalls, the output beat holds, the queue fills, and then
// in_ready_o drops until room frees up.
module ipv6_neighbor_solicit_builder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nsb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [nsb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [nsb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [63:0]                     target_addr_hi_i,
  input  logic [63:0]                     target_addr_lo_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [63:0]                     frame_word_o,
  output logic [3:0]                      valid_bytes_o,
  output logic                            last_word_o
);

  nsb_pkg::cfg_t cfg;
  nsb_pkg::req_t push_data, head;
  logic          push, pop, q_full, q_empty;

  nsb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nsb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .target_addr_hi_i (target_addr_hi_i),
    .target_addr_lo_i (target_addr_lo_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  nsb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  nsb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .empty_i       (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_word_o  (frame_word_o),
    .valid_bytes_o (valid_bytes_o),
    .last_word_o   (last_word_o)
  );

endmodule

>>> tb/ns_frame_checker.sv
// Checker for the neighbor solicitation builder: tracks config, predicts frame beats, compares.
module ns_frame_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [nsb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [nsb_pkg::APB_DATA_W-1:0]  pwdata,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [63:0]                     target_addr_hi_i,
  input  logic [63:0]                     target_addr_lo_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [63:0]                     frame_word_i,
  input  logic [3:0]                      valid_bytes_i,
  input  logic                            last_word_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     beats_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NS_WORDS       = 11;
  localparam logic [7:0] MCAST_PFX      = 8'h33;
  localparam logic [7:0] SOLICIT_PFX    = 8'hff;
  localparam logic [7:0] ETYPE_IPV6_HI  = 8'h86;
  localparam logic [7:0] ETYPE_IPV6_LO  = 8'hdd;
  localparam logic [7:0] IP_VERSION_TC  = 8'h60;
  localparam logic [7:0] NS_PAYLOAD_LEN = 8'd32;
  localparam logic [7:0] NH_ICMPV6      = 8'd58;
  localparam logic [7:0] HOP_LIMIT      = 8'd255;
  localparam logic [7:0] ICMP_NS_TYPE   = 8'd135;
  localparam logic [7:0] OPT_SRC_LLA    = 8'd1;
  localparam logic [7:0] OPT_LEN_UNITS  = 8'd1;
  localparam logic [3:0] BEAT_FULL      = 4'd8;
  localparam logic [3:0] BEAT_TAIL      = 4'd6;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } ns_beat_t;

  ns_beat_t    frame_beats_q[$];
  ns_beat_t    want;
  logic [63:0] own_ip_hi;
  logic [63:0] own_ip_lo;
  logic [47:0] own_mac;

  function automatic void queue_ns_frame(input logic [63:0] thi, input logic [63:0] tlo);
    logic [7:0]  fb [0:87];
    logic [31:0] acc;
    logic [15:0] ck;
    ns_beat_t    beat;
    for (int i = 0; i < 88; i++) fb[i] = '0;
    fb[0]  = MCAST_PFX;
    fb[1]  = MCAST_PFX;
    fb[2]  = SOLICIT_PFX;
    {fb[3], fb[4], fb[5]} = tlo[23:0];
    for (int i = 0; i < 6; i++) begin
      fb[6 + i]  = own_mac[47 - 8*i -: 8];
      fb[80 + i] = own_mac[47 - 8*i -: 8];
    end
    fb[12] = ETYPE_IPV6_HI;
    fb[13] = ETYPE_IPV6_LO;
    fb[14] = IP_VERSION_TC;
    fb[19] = NS_PAYLOAD_LEN;
    fb[20] = NH_ICMPV6;
    fb[21] = HOP_LIMIT;
    for (int i = 0; i < 8; i++) begin
      fb[22 + i] = own_ip_hi[63 - 8*i -: 8];
      fb[30 + i] = own_ip_lo[63 - 8*i -: 8];
      fb[38 + i] = thi[63 - 8*i -: 8];
      fb[46 + i] = tlo[63 - 8*i -: 8];
      fb[62 + i] = thi[63 - 8*i -: 8];
      fb[70 + i] = tlo[63 - 8*i -: 8];
    end
    fb[54] = ICMP_NS_TYPE;
    fb[78] = OPT_SRC_LLA;
    fb[79] = OPT_LEN_UNITS;
    // pseudo-header length and next header, then addresses and ICMPv6 body
    acc = 32'(NS_PAYLOAD_LEN) + 32'(NH_ICMPV6);
    for (int i = 22; i < 86; i += 2) acc += {16'h0, fb[i], fb[i + 1]};
    while (acc[31:16] != 0) acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    ck = ~acc[15:0];
    fb[56] = ck[15:8];
    fb[57] = ck[7:0];
    for (int w = 0; w < NS_WORDS; w++) begin
      for (int j = 0; j < 8; j++) beat.data[63 - 8*j -: 8] = fb[8*w + j];
      beat.nbytes = (w == NS_WORDS - 1) ? BEAT_TAIL : BEAT_FULL;
      beat.last   = (w == NS_WORDS - 1);
      frame_beats_q.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_hi = '0;
      own_ip_lo = '0;
      own_mac   = '0;
      frame_beats_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[nsb_pkg::APB_ADDR_W-1:3])
          nsb_pkg::REG_SRC_ADDR_HI: own_ip_hi = pwdata;
          nsb_pkg::REG_SRC_ADDR_LO: own_ip_lo = pwdata;
          nsb_pkg::REG_SRC_MAC:     own_mac   = pwdata[47:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) queue_ns_frame(target_addr_hi_i, target_addr_lo_i);
      if (out_valid_i && out_ready_i) begin
        if (frame_beats_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual word %h", $time, frame_word_i);
          fail_count_o++;
        end else begin
          want = frame_beats_q.pop_front();
          if (frame_word_i !== want.data) begin
            $display("%0t: frame_word expected %h actual %h", $time, want.data, frame_word_i);
            fail_count_o++;
          end
          if (valid_bytes_i !== want.nbytes) begin
            $display("%0t: valid_bytes expected %0d actual %0d", $time, want.nbytes,
                     valid_bytes_i);
            fail_count_o++;
          end
          if (last_word_i !== want.last) begin
            $display("%0t: last_word expected %b actual %b", $time, want.last, last_word_i);
            fail_count_o++;
          end
        end
      end
    end
    beats_due_o = frame_beats_q.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, APB setup, request stimulus, receiver stalls and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE_IDX = 2'd3;
  localparam int         SEGMENTS      = 8;
  localparam int         SEG_ITEMS     = 50;
  localparam int         LONG_HOLD     = 150;
  localparam int         DRAIN_CYCLES  = 20;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [nsb_pkg::APB_ADDR_W-1:0] paddr;
  logic [nsb_pkg::APB_DATA_W-1:0] pwdata;
  logic [nsb_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [63:0]                    target_addr_hi_i;
  logic [63:0]                    target_addr_lo_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [63:0]                    frame_word_o;
  logic [3:0]                     valid_bytes_o;
  logic                           last_word_o;

  int unsigned fail_count;
  int unsigned beats_due;
  bit          idle_en;
  bit          long_hold_req;
  bit          long_hold_done;

  ipv6_neighbor_solicit_builder_core uut (.*);

  ns_frame_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .target_addr_hi_i (target_addr_hi_i),
    .target_addr_lo_i (target_addr_lo_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_word_i     (frame_word_o),
    .valid_bytes_i    (valid_bytes_o),
    .last_word_i      (last_word_o),
    .fail_count_o     (fail_count),
    .beats_due_o      (beats_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready_i    = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_src(input logic [63:0] hi, input logic [63:0] lo, input logic [63:0] mac);
    apb_write(nsb_pkg::REG_SRC_ADDR_HI, hi);
    apb_write(nsb_pkg::REG_SRC_ADDR_LO, lo);
    apb_write(nsb_pkg::REG_SRC_MAC, mac);
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic offer_target(input logic [63:0] hi, input logic [63:0] lo);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    target_addr_hi_i <= hi;
    target_addr_lo_i <= lo;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_frames();
    in_valid_i <= 1'b0;
    while (beats_due != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_corners();
    offer_target('0, '0);
    offer_target('1, '1);
    offer_target(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    offer_target(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
    offer_target(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    offer_target(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    offer_target(64'hff02_0000_0000_0000, 64'h0000_0001_ff00_0001);
    offer_target(64'hfe80_0000_0000_0000, 64'h0211_22ff_fe33_4455);
    offer_target('0, 64'h0000_0000_00ff_ffff);
    offer_target('1, 64'hffff_ffff_ff00_0000);
  endtask

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    target_addr_hi_i = '0;
    target_addr_lo_i = '0;
    idle_en          = 1'b0;
    long_hold_req    = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config: all zero; this target makes the checksum come out as zero
    send_corners();
    offer_target('0, 64'h0000_0000_0000_3bd2);
    drain_frames();

    // all ones, with a write to the unused slot in between
    idle_en = 1'b1;
    load_src('1, '1, '1);
    apb_write(REG_SPARE_IDX, {$urandom, $urandom});
    send_corners();
    drain_frames();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: load_src({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        1: load_src('1, '1, '1);
        2: load_src('0, '0, {$urandom, 16'h0000, 16'h0000} & 64'hffff_0000_0000_0000);
        default: begin
          load_src(rand_word(), rand_word(), rand_word());
          apb_write(REG_SPARE_IDX, '1);
        end
      endcase
      idle_en = (seg < SEGMENTS - 2) && (seg % 3 != 1);
      if (seg == 2) long_hold_req = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) offer_target(rand_word(), rand_word());
      drain_frames();
    end

    if (fail_count == 0 && beats_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/nsb_pkg.sv
hdl/nsb_regs.sv
hdl/nsb_front.sv
hdl/nsb_queue.sv
hdl/nsb_back.sv
hdl/ipv6_neighbor_solicit_builder_core.sv
tb/ns_frame_checker.sv
tb/tb.sv
